// File: hw/rtl/jed_pkg.sv
// Package for the joystick event decoder: action codes, register indexes,
// and the structs passed between the configuration block, core and top level.
// No dependencies.
package jed_pkg;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_UP     = 3'd1,
        ACT_DOWN   = 3'd2,
        ACT_LEFT   = 3'd3,
        ACT_RIGHT  = 3'd4,
        ACT_SELECT = 3'd5,
        ACT_HOME   = 3'd6
    } action_t;

    localparam int unsigned AddrWidth = 5;
    localparam int unsigned DataWidth = 32;

    localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd0;
    localparam logic [2:0] REG_HIGH_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_POLARITY       = 3'd2;
    localparam logic [2:0] REG_INITIAL_REPEAT = 3'd3;
    localparam logic [2:0] REG_REPEAT         = 3'd4;
    localparam logic [2:0] REG_DEBOUNCE       = 3'd5;
    localparam logic [2:0] REG_LONG_PRESS     = 3'd6;

    typedef struct packed {
        logic [11:0] low_threshold;
        logic [11:0] high_threshold;
        logic [2:0]  polarity_bits;
        logic [15:0] initial_repeat_ms;
        logic [15:0] repeat_ms;
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
    } cfg_t;

    typedef struct packed {
        logic [11:0] axis_x;
        logic [11:0] axis_y;
        logic        switch_level;
        logic [31:0] now_ms;
    } sample_t;

    typedef struct packed {
        action_t action;
        action_t held_direction;
        logic    switch_raw_pressed;
        logic    long_press_held;
    } result_t;

endpackage

// File: hw/rtl/jed_if.sv
// Valid/ready channel interfaces for the joystick event decoder:
// one for input samples and one for results. No dependencies.
interface jed_sample_if;
    logic        valid;
    logic        ready;
    logic [11:0] axis_x;
    logic [11:0] axis_y;
    logic        switch_level;
    logic [31:0] now_ms;

    modport source (output valid, axis_x, axis_y, switch_level, now_ms, input ready);
    modport sink (input valid, axis_x, axis_y, switch_level, now_ms, output ready);
endinterface

interface jed_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [2:0] held_direction;
    logic       switch_raw_pressed;
    logic       long_press_held;

    modport source (output valid, action, held_direction, switch_raw_pressed,
                    long_press_held, input ready);
    modport sink (input valid, action, held_direction, switch_raw_pressed,
                  long_press_held, output ready);
endinterface

// File: hw/rtl/jed_cfg_regs.sv
// APB configuration registers for the joystick event decoder.
// Depends on jed_pkg.
module jed_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [jed_pkg::AddrWidth-1:0]  paddr,
    input  logic [jed_pkg::DataWidth-1:0]  pwdata,
    output logic [jed_pkg::DataWidth-1:0]  prdata,
    output logic                           pready,
    output jed_pkg::cfg_t                  cfg
);

    jed_pkg::cfg_t cfg_reg;
    jed_pkg::cfg_t cfg_next;
    logic [2:0]    reg_index;
    logic          wr_en;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                jed_pkg::REG_LOW_THRESHOLD:  cfg_next.low_threshold     = pwdata[11:0];
                jed_pkg::REG_HIGH_THRESHOLD: cfg_next.high_threshold    = pwdata[11:0];
                jed_pkg::REG_POLARITY:       cfg_next.polarity_bits     = pwdata[2:0];
                jed_pkg::REG_INITIAL_REPEAT: cfg_next.initial_repeat_ms = pwdata[15:0];
                jed_pkg::REG_REPEAT:         cfg_next.repeat_ms         = pwdata[15:0];
                jed_pkg::REG_DEBOUNCE:       cfg_next.debounce_ms       = pwdata[15:0];
                jed_pkg::REG_LONG_PRESS:     cfg_next.long_press_ms     = pwdata[15:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            jed_pkg::REG_LOW_THRESHOLD:  prdata = {20'd0, cfg_reg.low_threshold};
            jed_pkg::REG_HIGH_THRESHOLD: prdata = {20'd0, cfg_reg.high_threshold};
            jed_pkg::REG_POLARITY:       prdata = {29'd0, cfg_reg.polarity_bits};
            jed_pkg::REG_INITIAL_REPEAT: prdata = {16'd0, cfg_reg.initial_repeat_ms};
            jed_pkg::REG_REPEAT:         prdata = {16'd0, cfg_reg.repeat_ms};
            jed_pkg::REG_DEBOUNCE:       prdata = {16'd0, cfg_reg.debounce_ms};
            jed_pkg::REG_LONG_PRESS:     prdata = {16'd0, cfg_reg.long_press_ms};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_threshold     <= 12'd1000;
            cfg_reg.high_threshold    <= 12'd3000;
            cfg_reg.polarity_bits     <= 3'd1;
            cfg_reg.initial_repeat_ms <= 16'd400;
            cfg_reg.repeat_ms         <= 16'd150;
            cfg_reg.debounce_ms       <= 16'd30;
            cfg_reg.long_press_ms     <= 16'd800;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hw/rtl/jed_core.sv
// Decode core: switch debounce, long press, direction classify and repeat.
// Holds the decoder state; updates it when step is high. Depends on jed_pkg.
module jed_core (
    input  logic             clk,
    input  logic             rst_n,
    input  jed_pkg::cfg_t    cfg,
    input  logic             step,
    input  jed_pkg::sample_t sample,
    output jed_pkg::result_t result
);

    jed_pkg::action_t latched_dir_reg, latched_dir_next;
    logic             armed_reg, armed_next;
    logic [31:0]      deadline_reg, deadline_next;
    logic             pressed_reg, pressed_next;
    logic             lp_done_reg, lp_done_next;
    logic [31:0]      last_change_reg, last_change_next;
    logic [31:0]      press_start_reg, press_start_next;

    logic             raw;
    logic             xl, xh, yl, yh;
    logic             up_hit, down_hit, left_hit, right_hit;
    jed_pkg::action_t dir;
    jed_pkg::action_t sw_act;
    jed_pkg::action_t act;
    logic             changed;
    logic             in_window;
    logic [31:0]      since_change;
    logic [31:0]      since_press;
    logic [31:0]      past_deadline;
    logic             hold_long;

    assign raw = cfg.polarity_bits[2] ? !sample.switch_level : sample.switch_level;

    assign xl = sample.axis_x < cfg.low_threshold;
    assign xh = sample.axis_x > cfg.high_threshold;
    assign yl = sample.axis_y < cfg.low_threshold;
    assign yh = sample.axis_y > cfg.high_threshold;

    assign up_hit    = cfg.polarity_bits[0] ? yl : yh;
    assign down_hit  = cfg.polarity_bits[0] ? yh : yl;
    assign left_hit  = cfg.polarity_bits[1] ? xl : xh;
    assign right_hit = cfg.polarity_bits[1] ? xh : xl;

    always_comb
    begin
        if (up_hit)
            dir = jed_pkg::ACT_UP;
        else if (down_hit)
            dir = jed_pkg::ACT_DOWN;
        else if (left_hit)
            dir = jed_pkg::ACT_LEFT;
        else if (right_hit)
            dir = jed_pkg::ACT_RIGHT;
        else
            dir = jed_pkg::ACT_NONE;
    end

    assign changed       = raw != pressed_reg;
    assign since_change  = sample.now_ms - last_change_reg;
    assign in_window     = since_change < {16'd0, cfg.debounce_ms};
    assign since_press   = sample.now_ms - press_start_reg;
    assign past_deadline = sample.now_ms - deadline_reg;

    always_comb
    begin
        pressed_next     = pressed_reg;
        lp_done_next     = lp_done_reg;
        last_change_next = last_change_reg;
        press_start_next = press_start_reg;
        hold_long        = since_press >= {16'd0, cfg.long_press_ms};
        sw_act           = jed_pkg::ACT_NONE;
        if (!(changed && in_window))
        begin
            if (changed)
            begin
                pressed_next     = raw;
                last_change_next = sample.now_ms;
                if (raw)
                begin
                    press_start_next = sample.now_ms;
                    lp_done_next     = 1'b0;
                    hold_long        = cfg.long_press_ms == 16'd0;
                end
            end
            if (changed && !raw && !lp_done_reg)
                sw_act = jed_pkg::ACT_SELECT;
            else if (pressed_next && !lp_done_next && hold_long)
            begin
                lp_done_next = 1'b1;
                sw_act       = jed_pkg::ACT_HOME;
            end
        end
    end

    always_comb
    begin
        latched_dir_next = latched_dir_reg;
        armed_next       = armed_reg;
        deadline_next    = deadline_reg;
        act              = sw_act;
        if (sw_act == jed_pkg::ACT_NONE)
        begin
            if (dir == jed_pkg::ACT_NONE)
            begin
                latched_dir_next = jed_pkg::ACT_NONE;
                armed_next       = 1'b0;
                deadline_next    = '0;
            end
            else if (dir != latched_dir_reg)
            begin
                latched_dir_next = dir;
                armed_next       = 1'b1;
                deadline_next    = sample.now_ms + {16'd0, cfg.initial_repeat_ms};
                act              = dir;
            end
            else if (armed_reg && !past_deadline[31])
            begin
                deadline_next = sample.now_ms + {16'd0, cfg.repeat_ms};
                act           = dir;
            end
        end
    end

    assign result.action             = act;
    assign result.held_direction     = dir;
    assign result.switch_raw_pressed = raw;
    assign result.long_press_held    = pressed_next && lp_done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_dir_reg <= jed_pkg::ACT_NONE;
            armed_reg       <= 1'b0;
            deadline_reg    <= '0;
            pressed_reg     <= 1'b0;
            lp_done_reg     <= 1'b0;
            last_change_reg <= '0;
            press_start_reg <= '0;
        end
        else if (step)
        begin
            latched_dir_reg <= latched_dir_next;
            armed_reg       <= armed_next;
            deadline_reg    <= deadline_next;
            pressed_reg     <= pressed_next;
            lp_done_reg     <= lp_done_next;
            last_change_reg <= last_change_next;
            press_start_reg <= press_start_next;
        end
    end

    a_armed_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> latched_dir_reg != jed_pkg::ACT_NONE)
        else $error("repeat armed without a latched direction");

    a_select_releases: assert property (@(posedge clk) disable iff (!rst_n)
        step && act == jed_pkg::ACT_SELECT |=> !pressed_reg && !lp_done_reg)
        else $error("select without a debounced release");

    a_home_once: assert property (@(posedge clk) disable iff (!rst_n)
        step && act == jed_pkg::ACT_HOME |=> pressed_reg && lp_done_reg)
        else $error("home without marking the long press done");

    a_switch_event_holds_dir: assert property (@(posedge clk) disable iff (!rst_n)
        step && (act == jed_pkg::ACT_SELECT || act == jed_pkg::ACT_HOME)
        |=> $stable(latched_dir_reg) && $stable(armed_reg) && $stable(deadline_reg))
        else $error("switch event disturbed the direction state");

endmodule

// File: hw/rtl/joystick_event_decoder_top.sv
// Path: a transferred sample goes to the input register, then to the result register, which
// drives result valid; the core's state updates as an item moves between them.
// Throughput: one sample per cycle while the result side keeps up; the single
// result register lets a new sample enter while an old result waits.
// Reset: rst_n asynchronous active low; clears state, loads register defaults.
module joystick_event_decoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    jed_sample_if.sink                    sample_ch,
    jed_result_if.source                  result_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jed_pkg::AddrWidth-1:0] paddr,
    input  logic [jed_pkg::DataWidth-1:0] pwdata,
    output logic [jed_pkg::DataWidth-1:0] prdata,
    output logic                          pready
);

    jed_pkg::cfg_t    cfg;
    jed_pkg::sample_t in_data_reg;
    logic             in_valid_reg;
    jed_pkg::result_t core_result;
    jed_pkg::result_t out_data_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             take;

    assign advance         = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign sample_ch.ready = !in_valid_reg || advance;
    assign take            = sample_ch.valid && sample_ch.ready;

    jed_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jed_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .sample (in_data_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg.axis_x       <= sample_ch.axis_x;
            in_data_reg.axis_y       <= sample_ch.axis_y;
            in_data_reg.switch_level <= sample_ch.switch_level;
            in_data_reg.now_ms       <= sample_ch.now_ms;
        end
        if (advance)
            out_data_reg <= core_result;
    end

    assign result_ch.valid              = out_valid_reg;
    assign result_ch.action             = out_data_reg.action;
    assign result_ch.held_direction     = out_data_reg.held_direction;
    assign result_ch.switch_raw_pressed = out_data_reg.switch_raw_pressed;
    assign result_ch.long_press_held    = out_data_reg.long_press_held;

endmodule
